// File: hw/rtl/gpio_pkg.sv
`timescale 1ns / 1ps

package gpio_pkg;

    // Fixed widths of the port
    localparam int DATA_W    = 32;
    localparam int HALF_PINS = 16;
    localparam int PIN_COUNT_DEFAULT = 32;

    // Request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_DR       = 3'd0;
    localparam logic [2:0] REG_GDIR     = 3'd1;
    localparam logic [2:0] REG_PSR      = 3'd2;
    localparam logic [2:0] REG_ICR1     = 3'd3;
    localparam logic [2:0] REG_ICR2     = 3'd4;
    localparam logic [2:0] REG_IMR      = 3'd5;
    localparam logic [2:0] REG_ISR      = 3'd6;
    localparam logic [2:0] REG_EDGE_SEL = 3'd7;

    // Interrupt condition codes
    localparam logic [1:0] ICR_LOW_LEVEL  = 2'd0;
    localparam logic [1:0] ICR_HIGH_LEVEL = 2'd1;
    localparam logic [1:0] ICR_RISE       = 2'd2;
    localparam logic [1:0] ICR_FALL       = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [2:0]        reg_index;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pad_levels;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] pad_out;
        logic [DATA_W-1:0] pad_drive_enable;
        logic              irq_low_half;
        logic              irq_high_half;
    } rsp_t;

    // Register access decoded from one request
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [2:0]        idx;
        logic [DATA_W-1:0] wdata;
    } access_t;

endpackage

// File: hw/rtl/gpio_lane.sv
`timescale 1ns / 1ps

module gpio_lane
(
    input  logic       now,
    input  logic       was,
    input  logic [1:0] code,
    input  logic       both_edge,
    output logic       hit
);

    // Evaluate one pin's trigger condition
    always_comb
    begin
        case (code)
            gpio_pkg::ICR_LOW_LEVEL:  hit = !now;
            gpio_pkg::ICR_HIGH_LEVEL: hit = now;
            gpio_pkg::ICR_RISE:       hit = !was && now;
            gpio_pkg::ICR_FALL:       hit = was && !now;
            default:                  hit = 1'b0;
        endcase
        // Either-edge select overrides the code
        if (both_edge)
        begin
            hit = (now != was);
        end
    end

endmodule

// File: hw/rtl/gpio_regs.sv
`timescale 1ns / 1ps

module gpio_regs
#(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  gpio_pkg::access_t           acc,
    input  logic [PIN_COUNT-1:0]        pads,
    input  logic [PIN_COUNT-1:0]        hits,
    output logic [gpio_pkg::DATA_W-1:0] icr_low,
    output logic [gpio_pkg::DATA_W-1:0] icr_high,
    output logic [PIN_COUNT-1:0]        any_edge,
    output logic [PIN_COUNT-1:0]        last_pads,
    output logic [gpio_pkg::DATA_W-1:0] rd_data,
    output logic [PIN_COUNT-1:0]        data_next,
    output logic [PIN_COUNT-1:0]        dir_next,
    output logic                        irq_lo_next,
    output logic                        irq_hi_next
);

    localparam int W = gpio_pkg::DATA_W;

    logic [PIN_COUNT-1:0] data_reg,   data_next_int;
    logic [PIN_COUNT-1:0] dir_reg,    dir_next_int;
    logic [W-1:0]         icr_lo_reg, icr_lo_next;
    logic [W-1:0]         icr_hi_reg, icr_hi_next;
    logic [PIN_COUNT-1:0] mask_reg,   mask_next;
    logic [PIN_COUNT-1:0] status_reg, status_next;
    logic [PIN_COUNT-1:0] edge_reg,   edge_next;
    logic [PIN_COUNT-1:0] last_pads_reg;
    logic [PIN_COUNT-1:0] clr;
    logic [PIN_COUNT-1:0] wmask;
    logic [W-1:0]         pend;

    assign wmask = acc.wdata[PIN_COUNT-1:0];

    // Read the registers as they stand before this request
    always_comb
    begin
        rd_data = '0;
        if (acc.rd_en)
        begin
            case (acc.idx)
                gpio_pkg::REG_DR:
                    rd_data = W'((data_reg & dir_reg) | (pads & ~dir_reg));
                gpio_pkg::REG_GDIR:     rd_data = W'(dir_reg);
                gpio_pkg::REG_PSR:      rd_data = W'(pads);
                gpio_pkg::REG_ICR1:     rd_data = icr_lo_reg;
                gpio_pkg::REG_ICR2:     rd_data = icr_hi_reg;
                gpio_pkg::REG_IMR:      rd_data = W'(mask_reg);
                gpio_pkg::REG_ISR:      rd_data = W'(status_reg);
                default:                rd_data = W'(edge_reg);
            endcase
        end
    end

    // Apply the write, then merge lane hits into status (a hit beats a clear)
    always_comb
    begin
        data_next_int = data_reg;
        dir_next_int  = dir_reg;
        icr_lo_next   = icr_lo_reg;
        icr_hi_next   = icr_hi_reg;
        mask_next     = mask_reg;
        edge_next     = edge_reg;
        clr           = '0;
        if (acc.wr_en)
        begin
            case (acc.idx)
                gpio_pkg::REG_DR:   data_next_int = wmask;
                gpio_pkg::REG_GDIR: dir_next_int  = wmask;
                gpio_pkg::REG_PSR:  ;
                gpio_pkg::REG_ICR1: icr_lo_next   = acc.wdata;
                gpio_pkg::REG_ICR2: icr_hi_next   = acc.wdata;
                gpio_pkg::REG_IMR:  mask_next     = wmask;
                gpio_pkg::REG_ISR:  clr           = wmask;
                default:            edge_next     = wmask;
            endcase
        end
        status_next = (status_reg & ~clr) | hits;
        pend        = W'(status_next & mask_next);
    end

    assign data_next   = data_next_int;
    assign dir_next    = dir_next_int;
    assign irq_lo_next = |pend[gpio_pkg::HALF_PINS-1:0];
    assign irq_hi_next = |pend[W-1:gpio_pkg::HALF_PINS];
    assign icr_low     = icr_lo_reg;
    assign icr_high    = icr_hi_reg;
    assign any_edge    = edge_reg;
    assign last_pads   = last_pads_reg;

    // Advance the register state once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg      <= '0;
            dir_reg       <= '0;
            icr_lo_reg    <= '0;
            icr_hi_reg    <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            edge_reg      <= '0;
            last_pads_reg <= '0;
        end
        else if (advance)
        begin
            data_reg      <= data_next_int;
            dir_reg       <= dir_next_int;
            icr_lo_reg    <= icr_lo_next;
            icr_hi_reg    <= icr_hi_next;
            mask_reg      <= mask_next;
            status_reg    <= status_next;
            edge_reg      <= edge_next;
            last_pads_reg <= pads;
        end
    end

    // A detection always lands in status, even under a clear
    a_hit_wins: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((status_reg & $past(hits)) == $past(hits)))
        else $error("status lost a detection");

    // Status only gains bits from lane hits
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((status_reg & ~$past(status_reg | hits)) == '0))
        else $error("status bit set without a hit");

    // Status holds between requests
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(status_reg))
        else $error("status changed while idle");

endmodule

// File: hw/rtl/gpio_port_with_edge_level_irq.sv
`timescale 1ns / 1ps

// 32-pin GPIO port with level and edge interrupt detection.
// Request channel (req_valid/req_ready/req): each request carries one pad
// sample plus an optional register read or write (DR, GDIR, PSR, ICR1,
// ICR2, IMR, ISR, EDGE_SEL). Send one request per clock to track the pads.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one response per
// request, in order: read data, pad outputs, drive enables and the two
// interrupt lines (pins 0-15, pins 16-31) as they stand after the request.
// The response is registered: it is valid in the cycle after the request. Throughput:
// one request per cycle while responses are taken; the per-pin detector lanes
// and the register update are combinational ahead of the response register.
// A stalled receiver keeps its response in the response register; a new
// request is still taken in the same cycle the held response is taken, and
// otherwise req_ready drops until it is.
// Reset clears the port registers and the previous pad sample to zero: all pins
// are inputs, all interrupts masked, no response pending.
module gpio_port_with_edge_level_irq
#(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  gpio_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output gpio_pkg::rsp_t rsp
);

    localparam int W = gpio_pkg::DATA_W;

    logic                 accept;
    gpio_pkg::access_t    acc;
    logic [PIN_COUNT-1:0] pads;
    logic [PIN_COUNT-1:0] hits;
    logic [W-1:0]         icr_low;
    logic [W-1:0]         icr_high;
    logic [2*W-1:0]       icr_all;
    logic [PIN_COUNT-1:0] any_edge;
    logic [PIN_COUNT-1:0] last_pads;
    logic [W-1:0]         rd_data;
    logic [PIN_COUNT-1:0] data_next;
    logic [PIN_COUNT-1:0] dir_next;
    logic                 irq_lo_next;
    logic                 irq_hi_next;
    logic                 rsp_valid_reg;
    gpio_pkg::rsp_t       rsp_reg;

    // Take a request whenever the response register is free or draining
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // Decode the register access
    assign acc.rd_en = (req.req_type == gpio_pkg::REQ_READ);
    assign acc.wr_en = (req.req_type == gpio_pkg::REQ_WRITE);
    assign acc.idx   = req.reg_index;
    assign acc.wdata = req.write_data;

    assign pads    = req.pad_levels[PIN_COUNT-1:0];
    assign icr_all = {icr_high, icr_low};

    // One detector lane per implemented pin
    for (genvar i = 0; i < PIN_COUNT; i++)
    begin : g_lane
        gpio_lane u_lane
        (
            .now       (pads[i]),
            .was       (last_pads[i]),
            .code      (icr_all[2*i +: 2]),
            .both_edge (any_edge[i]),
            .hit       (hits[i])
        );
    end

    // Register file and status merge
    gpio_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .acc         (acc),
        .pads        (pads),
        .hits        (hits),
        .icr_low     (icr_low),
        .icr_high    (icr_high),
        .any_edge    (any_edge),
        .last_pads   (last_pads),
        .rd_data     (rd_data),
        .data_next   (data_next),
        .dir_next    (dir_next),
        .irq_lo_next (irq_lo_next),
        .irq_hi_next (irq_hi_next)
    );

    // Hold the response valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load the response payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.read_data        <= rd_data;
            rsp_reg.pad_out          <= W'(data_next);
            rsp_reg.pad_drive_enable <= W'(dir_next);
            rsp_reg.irq_low_half     <= irq_lo_next;
            rsp_reg.irq_high_half    <= irq_hi_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every accepted request leaves a response pending
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted request produced no response");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS   = 550;
    localparam int QUIET_ITEMS    = 80;
    localparam int LONG_STALL     = 60;
    localparam int STALL_AT_COUNT = 200;
    localparam int DRAIN_AT_ITEM  = 300;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 8;
    // Unassigned request type, handled as a plain tick
    localparam logic [1:0] REQ_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    gpio_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    gpio_pkg::rsp_t rsp;

    // Requests waiting to be sent, with a flag that holds the request back
    // until every outstanding response has come
    gpio_pkg::req_t pending_reqs[$];
    bit   pending_drain[$];
    // Responses predicted for accepted requests, oldest first
    gpio_pkg::rsp_t exp_rsps[$];

    // Shadow copy of the port state
    logic [31:0] shadow_dr;
    logic [31:0] shadow_gdir;
    logic [31:0] shadow_icr1;
    logic [31:0] shadow_icr2;
    logic [31:0] shadow_imr;
    logic [31:0] shadow_isr;
    logic [31:0] shadow_edge;
    logic [31:0] prev_pads;

    int  error_count = 0;
    int  req_count = 0;
    int  quiet_cycles = 0;
    bit  req_taken = 1'b0;
    int  send_idle = 0;
    int  recv_idle = 0;
    int  long_left = 0;
    bit  long_done = 1'b0;

    gpio_port_with_edge_level_irq u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the shadow state by one request and return its response
    function automatic gpio_pkg::rsp_t gpio_next_rsp(gpio_pkg::req_t r);
        gpio_pkg::rsp_t o;
        logic [31:0] hits;
        logic [31:0] clr;
        logic [31:0] pend;
        logic [1:0]  code;
        logic        now_b;
        logic        was_b;
        logic        hit;
        hits = '0;
        clr  = '0;
        o    = '0;
        // Detect with the configuration held before this request
        for (int i = 0; i < gpio_pkg::DATA_W; i++)
        begin
            now_b = r.pad_levels[i];
            was_b = prev_pads[i];
            if (i < gpio_pkg::HALF_PINS)
                code = shadow_icr1[2*i +: 2];
            else
                code = shadow_icr2[2*(i-gpio_pkg::HALF_PINS) +: 2];
            if (shadow_edge[i])
                hit = (now_b != was_b);
            else if (code == gpio_pkg::ICR_LOW_LEVEL)
                hit = !now_b;
            else if (code == gpio_pkg::ICR_HIGH_LEVEL)
                hit = now_b;
            else if (code == gpio_pkg::ICR_RISE)
                hit = !was_b && now_b;
            else
                hit = was_b && !now_b;
            hits[i] = hit;
        end
        case (r.req_type)
            gpio_pkg::REQ_READ:
            begin
                case (r.reg_index)
                    gpio_pkg::REG_DR:   o.read_data = (shadow_dr & shadow_gdir)
                                                    | (r.pad_levels & ~shadow_gdir);
                    gpio_pkg::REG_GDIR: o.read_data = shadow_gdir;
                    gpio_pkg::REG_PSR:  o.read_data = r.pad_levels;
                    gpio_pkg::REG_ICR1: o.read_data = shadow_icr1;
                    gpio_pkg::REG_ICR2: o.read_data = shadow_icr2;
                    gpio_pkg::REG_IMR:  o.read_data = shadow_imr;
                    gpio_pkg::REG_ISR:  o.read_data = shadow_isr;
                    default:            o.read_data = shadow_edge;
                endcase
            end
            gpio_pkg::REQ_WRITE:
            begin
                case (r.reg_index)
                    gpio_pkg::REG_DR:   shadow_dr   = r.write_data;
                    gpio_pkg::REG_GDIR: shadow_gdir = r.write_data;
                    gpio_pkg::REG_PSR:  ;
                    gpio_pkg::REG_ICR1: shadow_icr1 = r.write_data;
                    gpio_pkg::REG_ICR2: shadow_icr2 = r.write_data;
                    gpio_pkg::REG_IMR:  shadow_imr  = r.write_data;
                    gpio_pkg::REG_ISR:  clr         = r.write_data;
                    default:            shadow_edge = r.write_data;
                endcase
            end
            default: ;
        endcase
        // Detection wins over a clear of the same bit
        shadow_isr = (shadow_isr & ~clr) | hits;
        prev_pads  = r.pad_levels;
        pend = shadow_isr & shadow_imr;
        o.pad_out          = shadow_dr;
        o.pad_drive_enable = shadow_gdir;
        o.irq_low_half     = |pend[gpio_pkg::HALF_PINS-1:0];
        o.irq_high_half    = |pend[gpio_pkg::DATA_W-1:gpio_pkg::HALF_PINS];
        return o;
    endfunction

    // Monitor: check responses, then predict for accepted requests
    always @(posedge clk)
    begin : monitor
        gpio_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (exp_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = exp_rsps.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, rsp.read_data);
                        error_count++;
                    end
                    if (rsp.pad_out !== want.pad_out)
                    begin
                        $display("%0t: pad_out expected %h actual %h",
                                 $time, want.pad_out, rsp.pad_out);
                        error_count++;
                    end
                    if (rsp.pad_drive_enable !== want.pad_drive_enable)
                    begin
                        $display("%0t: pad_drive_enable expected %h actual %h",
                                 $time, want.pad_drive_enable, rsp.pad_drive_enable);
                        error_count++;
                    end
                    if (rsp.irq_low_half !== want.irq_low_half)
                    begin
                        $display("%0t: irq_low_half expected %b actual %b",
                                 $time, want.irq_low_half, rsp.irq_low_half);
                        error_count++;
                    end
                    if (rsp.irq_high_half !== want.irq_high_half)
                    begin
                        $display("%0t: irq_high_half expected %b actual %b",
                                 $time, want.irq_high_half, rsp.irq_high_half);
                        error_count++;
                    end
                end
            end
            req_taken = req_valid && req_ready;
            if (req_taken)
            begin
                exp_rsps.push_back(gpio_next_rsp(req));
                req_count++;
            end
            if (req_taken || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Driver: present the next request at the falling edge
    always @(negedge clk)
    begin : driver
        logic nv;
        gpio_pkg::req_t np;
        bit   calm;
        if (rst_n)
        begin
            nv = req_valid;
            np = req;
            calm = (pending_reqs.size() <= QUIET_ITEMS);
            if (!(req_valid && !req_taken))
            begin
                nv = 1'b0;
                if (send_idle > 0)
                    send_idle--;
                else if (pending_reqs.size() > 0)
                begin
                    // Hold back a drain-marked request until all responses are in
                    if (pending_drain[0] && exp_rsps.size() != 0)
                        nv = 1'b0;
                    else if (!calm && $urandom_range(0, 9) == 0)
                        send_idle = $urandom_range(1, 5) - 1;
                    else
                    begin
                        np = pending_reqs.pop_front();
                        void'(pending_drain.pop_front());
                        nv = 1'b1;
                    end
                end
            end
            req_valid <= nv;
            req <= np;
        end
    end

    // Receiver: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin : receiver
        logic nr;
        if (rst_n)
        begin
            nr = 1'b1;
            if (pending_reqs.size() <= QUIET_ITEMS && long_left == 0)
                nr = 1'b1;
            else if (long_left > 0)
            begin
                long_left--;
                nr = 1'b0;
            end
            else if (!long_done && req_count >= STALL_AT_COUNT)
            begin
                long_done = 1'b1;
                long_left = LONG_STALL - 1;
                nr = 1'b0;
            end
            else if (recv_idle > 0)
            begin
                recv_idle--;
                nr = 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                recv_idle = $urandom_range(1, 5) - 1;
                nr = 1'b0;
            end
            rsp_ready <= nr;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic add_req(logic [1:0] kind, logic [2:0] idx, logic [31:0] wd,
                           logic [31:0] pads, bit drain);
        gpio_pkg::req_t r;
        r.req_type   = kind;
        r.reg_index  = idx;
        r.write_data = wd;
        r.pad_levels = pads;
        pending_reqs.push_back(r);
        pending_drain.push_back(drain);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_pads(logic [31:0] last);
        case ($urandom_range(0, 6))
            0, 1:    return last;
            2:       return last ^ (32'h1 << $urandom_range(0, 31));
            3:       return last ^ ($urandom & $urandom);
            4:       return '0;
            5:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus and end of run
    initial
    begin : stimulus
        logic [31:0] pads;
        logic [1:0]  kind;
        int          pick;
        shadow_dr   = '0;
        shadow_gdir = '0;
        shadow_icr1 = '0;
        shadow_icr2 = '0;
        shadow_imr  = '0;
        shadow_isr  = '0;
        shadow_edge = '0;
        prev_pads   = '0;

        // Directed: register extremes, every trigger kind, corner cases
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_DR,   '0,  32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_PSR,  '0,  32'hA5A5_A5A5, 1'b0);
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_GDIR, 32'hFFFF_0000, '0, 1'b0);
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_DR,   32'hFFFF_FFFF, '0, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_DR,   '0,  32'h00FF_00FF, 1'b0);
        // Low level on every pin, all unmasked: status sets on every tick
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_IMR,  32'hFFFF_FFFF, '0, 1'b0);
        // Clear while the level still holds: the detection keeps the bit set
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_ISR,  32'hFFFF_FFFF, '0, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_ISR,  '0,  '0,            1'b0);
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_ICR1, 32'hAAAA_AAAA, '0, 1'b0);
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_ICR2, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_ISR,  32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_TICK,  gpio_pkg::REG_DR,   '0,  '0,            1'b0);
        add_req(gpio_pkg::REQ_TICK,  gpio_pkg::REG_DR,   '0,  32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_EDGE_SEL, 32'h0000_FF00, '0, 1'b0);
        add_req(gpio_pkg::REQ_TICK,  gpio_pkg::REG_DR,   '0,  32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_EDGE_SEL, '0, 32'hFFFF_FFFF, 1'b0);
        // Write to the pad status register is ignored
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_PSR,  32'hFFFF_FFFF, '0, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_PSR,  '0,  32'h5A5A_5A5A, 1'b0);
        // Request type 3 acts as a plain tick
        add_req(REQ_SPARE,           gpio_pkg::REG_ISR,  32'hFFFF_FFFF,
                32'h5A5A_5A5A, 1'b0);
        add_req(gpio_pkg::REQ_WRITE, gpio_pkg::REG_ICR1, 32'h5555_5555,
                32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_TICK,  gpio_pkg::REG_DR,   '0,  32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_ICR1, '0,  32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_ICR2, '0,  32'hFFFF_FFFF, 1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_IMR,  '0,  '0,            1'b0);
        add_req(gpio_pkg::REQ_READ,  gpio_pkg::REG_GDIR, '0,  '0,            1'b0);

        // Random: mostly ticks and accesses over drifting pad samples
        pads = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                kind = gpio_pkg::REQ_TICK;
            else if (pick < 7)
                kind = gpio_pkg::REQ_READ;
            else if (pick < 9)
                kind = gpio_pkg::REQ_WRITE;
            else
                kind = REQ_SPARE;
            pads = pick_pads(pads);
            add_req(kind, 3'($urandom_range(0, 7)), pick_word(), pads,
                    (n == 0) || (n == DRAIN_AT_ITEM));
        end

        // Reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain, then allow the pipeline to settle
        while (pending_reqs.size() != 0 || req_valid || exp_rsps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
